// ===== rtl/mfs_pkg.sv =====
// Shared types, register codes and helper functions of the D3Q15 MRT forcing-term block.
package mfs_pkg;

    // Register indexes of the configuration port.
    typedef enum logic [2:0] {
        CFG_REF_DEN = 3'd0,
        CFG_GRAV_X  = 3'd1,
        CFG_GRAV_Y  = 3'd2,
        CFG_GRAV_Z  = 3'd3,
        CFG_SIGMA   = 3'd4,
        CFG_LAMBDA  = 3'd5
    } t_cfg_idx;

    localparam logic [30:0] REF_DEN_RESET = 31'd65536;
    localparam logic [16:0] LAMBDA_RESET  = 17'd65536;
    localparam logic [3:0]  MOMENT_LAST   = 4'd14;

    // Reciprocal of three for exact 33-bit division, and the offset that makes
    // a signed 32-bit value a nonnegative multiple-of-three shift.
    localparam logic [31:0] DIV3_MAGIC  = 32'hAAAAAAAB;
    localparam logic [31:0] DIV3_OFFSET = 32'd715827883;

    // Live configuration values.
    typedef struct packed {
        logic [30:0]        ref_den;
        logic signed [31:0] grav_x;
        logic signed [31:0] grav_y;
        logic signed [31:0] grav_z;
        logic signed [31:0] sigma;
        logic [16:0]        lambda;
    } t_cfg;

    // One classified cell, handed from the front to the back.
    typedef struct packed {
        logic [31:0]       tag;
        logic [2:0][31:0]  fv;
        logic [2:0][35:0]  q3;
        logic [8:0][55:0]  p;
        logic [63:0]       tension;
        logic              zdiv;
        logic              s_neg;
        logic              tfault;
        logic              ff;
    } t_job;

    // Magnitude of a signed 32-bit value.
    function automatic logic [31:0] abs32(input logic [31:0] x);
        return x[31] ? 32'(~x + 32'd1) : x;
    endfunction

    // Saturate to 32 bits; the top bit of the result flags a clamp.
    function automatic logic [32:0] sat32(input logic signed [71:0] x);
        if (x > 72'sd2147483647) begin
            return {1'b1, 32'h7FFFFFFF};
        end else if (x < -72'sd2147483648) begin
            return {1'b1, 32'h80000000};
        end else begin
            return {1'b0, x[31:0]};
        end
    endfunction

endpackage

// ===== rtl/mfs_front.sv =====
// Front part: accepts a cell, runs the multiply sequence and the tension divider.
module mfs_front #(
    parameter int FRAC_BITS = 16,
    parameter int TAG_BITS  = 20
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  mfs_pkg::t_cfg       i_cfg,
    input  logic                i_start,
    output logic                o_busy,
    input  logic [TAG_BITS-1:0] i_cell_index,
    input  logic signed [31:0]  i_force_x,
    input  logic signed [31:0]  i_force_y,
    input  logic signed [31:0]  i_force_z,
    input  logic [30:0]         i_density,
    input  logic signed [31:0]  i_velocity_x,
    input  logic signed [31:0]  i_velocity_y,
    input  logic signed [31:0]  i_velocity_z,
    input  logic signed [31:0]  i_pseudo_potential,
    input  logic                i_full,
    output logic                o_push,
    output mfs_pkg::t_job       o_job
);
    import mfs_pkg::*;

    typedef enum logic [4:0] {
        F_IDLE = 5'b00001,
        F_MUL  = 5'b00010,
        F_DSET = 5'b00100,
        F_DIV  = 5'b01000,
        F_DONE = 5'b10000
    } t_fstate;

    // Multiply sequence: first step of each group.
    localparam logic [4:0] ST_GRAV = 5'd0;
    localparam logic [4:0] ST_FSQ  = 5'd3;
    localparam logic [4:0] ST_UF   = 5'd6;
    localparam logic [4:0] ST_PSI  = 5'd15;
    localparam logic [4:0] ST_SL   = 5'd16;
    localparam logic [4:0] ST_DIV3 = 5'd17;
    localparam logic [4:0] ST_NUM  = 5'd20;
    localparam logic [4:0] ST_DEN  = 5'd24;
    localparam logic [4:0] ST_END  = 5'd26;

    t_fstate             r_state;
    logic [4:0]          r_step;
    logic [31:0]         r_tag;
    logic signed [31:0]  r_frc [3];
    logic signed [31:0]  r_vel [3];
    logic signed [31:0]  r_psi;
    logic signed [31:0]  r_drho;
    logic signed [31:0]  r_fv [3];
    logic                r_ff;
    logic [63:0]         r_fsq;
    logic [55:0]         r_p [9];
    logic [35:0]         r_q3 [3];
    logic [62:0]         r_pp;
    logic [52:0]         r_a;
    logic [119:0]        r_num;
    logic [95:0]         r_den;
    logic signed [67:0]  r_prod;
    logic [121:0]        r_rem;
    logic [159:0]        r_dsh;
    logic [62:0]         r_quo;
    logic [5:0]          r_cnt;
    logic                r_tfault;
    logic                r_zdiv;

    logic signed [33:0]  ma;
    logic signed [33:0]  mb;
    logic [4:0]          cstep;
    logic signed [67:0]  rprod;
    logic signed [33:0]  d_s;
    logic [31:0]         d_abs;
    logic [32:0]         y [3];
    logic [121:0]        div_n;
    logic [96:0]         div_d;
    logic [159:0]        div_lim;
    logic [30:0]         qy;
    logic [1:0]          ry;
    logic signed [35:0]  qx;
    logic signed [35:0]  q3_val;
    logic [32:0]         fsat;
    logic [63:0]         tmag;

    // Divisor term of the tension and its magnitude.
    assign d_s   = $signed(34'(1) << (FRAC_BITS + 1)) - $signed({17'b0, i_cfg.lambda});
    assign d_abs = d_s[33] ? 32'(-d_s) : d_s[31:0];

    assign cstep = r_step - 5'd1;
    assign rprod = (r_prod + (68'sd1 <<< (FRAC_BITS - 1))) >>> FRAC_BITS;

    // Offset forces for the exact division by three.
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            y[i] = {1'b0, ~r_fv[i][31], r_fv[i][30:0]} + 33'd1;
        end
    end

    // Operand selection of the shared multiplier.
    always_comb begin
        ma = '0;
        mb = '0;
        case (r_step)
            5'd0:  begin ma = 34'(r_drho); mb = 34'(i_cfg.grav_x); end
            5'd1:  begin ma = 34'(r_drho); mb = 34'(i_cfg.grav_y); end
            5'd2:  begin ma = 34'(r_drho); mb = 34'(i_cfg.grav_z); end
            5'd3:  begin ma = {2'b0, abs32(r_fv[0])}; mb = {2'b0, abs32(r_fv[0])}; end
            5'd4:  begin ma = {2'b0, abs32(r_fv[1])}; mb = {2'b0, abs32(r_fv[1])}; end
            5'd5:  begin ma = {2'b0, abs32(r_fv[2])}; mb = {2'b0, abs32(r_fv[2])}; end
            5'd6:  begin ma = 34'(r_vel[0]); mb = 34'(r_fv[0]); end
            5'd7:  begin ma = 34'(r_vel[0]); mb = 34'(r_fv[1]); end
            5'd8:  begin ma = 34'(r_vel[0]); mb = 34'(r_fv[2]); end
            5'd9:  begin ma = 34'(r_vel[1]); mb = 34'(r_fv[0]); end
            5'd10: begin ma = 34'(r_vel[1]); mb = 34'(r_fv[1]); end
            5'd11: begin ma = 34'(r_vel[1]); mb = 34'(r_fv[2]); end
            5'd12: begin ma = 34'(r_vel[2]); mb = 34'(r_fv[0]); end
            5'd13: begin ma = 34'(r_vel[2]); mb = 34'(r_fv[1]); end
            5'd14: begin ma = 34'(r_vel[2]); mb = 34'(r_fv[2]); end
            5'd15: begin ma = {2'b0, abs32(r_psi)}; mb = {2'b0, abs32(r_psi)}; end
            5'd16: begin ma = {2'b0, abs32(i_cfg.sigma)}; mb = {17'b0, i_cfg.lambda}; end
            5'd17: begin ma = {1'b0, y[0]}; mb = {2'b0, DIV3_MAGIC}; end
            5'd18: begin ma = {1'b0, y[1]}; mb = {2'b0, DIV3_MAGIC}; end
            5'd19: begin ma = {1'b0, y[2]}; mb = {2'b0, DIV3_MAGIC}; end
            5'd20: begin ma = {2'b0, r_a[31:0]}; mb = {2'b0, r_fsq[31:0]}; end
            5'd21: begin ma = {2'b0, r_a[31:0]}; mb = {2'b0, r_fsq[63:32]}; end
            5'd22: begin ma = {13'b0, r_a[52:32]}; mb = {2'b0, r_fsq[31:0]}; end
            5'd23: begin ma = {13'b0, r_a[52:32]}; mb = {2'b0, r_fsq[63:32]}; end
            5'd24: begin ma = {2'b0, r_pp[31:0]}; mb = {2'b0, d_abs}; end
            5'd25: begin ma = {3'b0, r_pp[62:32]}; mb = {2'b0, d_abs}; end
            default: begin ma = '0; mb = '0; end
        endcase
    end

    // Total force of the axis whose buoyancy product has just arrived.
    always_comb begin
        logic signed [31:0] frc;
        case (cstep)
            5'd1:    frc = r_frc[1];
            5'd2:    frc = r_frc[2];
            default: frc = r_frc[0];
        endcase
        fsat = sat32({{40{frc[31]}}, frc} + {{4{rprod[67]}}, rprod});
    end

    // Quotient and remainder by three, then round(-7F/3) half up.
    always_comb begin
        logic [32:0] ysel;
        logic signed [31:0] q;
        logic signed [35:0] c;
        case (cstep)
            5'd18:   ysel = y[1];
            5'd19:   ysel = y[2];
            default: ysel = y[0];
        endcase
        qy = r_prod[63:33];
        ry = 2'(ysel[1:0] - 2'(qy[1:0] * 2'd3));
        q  = $signed(32'(qy)) - $signed(DIV3_OFFSET);
        qx = {{4{q[31]}}, q};
        case (ry)
            2'd1:    c = -36'sd2;
            2'd2:    c = -36'sd5;
            default: c = 36'sd0;
        endcase
        q3_val = qx - (qx <<< 3) + c;
    end

    // Tension numerator and divisor for the rounded quotient.
    assign div_n   = 122'({r_num, 1'b0}) + 122'(r_den);
    assign div_d   = {r_den, 1'b0};
    assign div_lim = (160'(div_d) << 62) + 160'(div_d);

    // Sequencer.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= F_IDLE;
            r_step  <= '0;
            r_cnt   <= '0;
        end else begin
            case (r_state)
                F_IDLE: begin
                    if (i_start) begin
                        r_tag    <= 32'(i_cell_index);
                        r_frc[0] <= i_force_x;
                        r_frc[1] <= i_force_y;
                        r_frc[2] <= i_force_z;
                        r_vel[0] <= i_velocity_x;
                        r_vel[1] <= i_velocity_y;
                        r_vel[2] <= i_velocity_z;
                        r_psi    <= i_pseudo_potential;
                        r_drho   <= $signed({1'b0, i_density}) - $signed({1'b0, i_cfg.ref_den});
                        r_ff     <= 1'b0;
                        r_fsq    <= '0;
                        r_num    <= '0;
                        r_den    <= '0;
                        r_step   <= ST_GRAV;
                        r_state  <= F_MUL;
                    end
                end
                F_MUL: begin
                    r_prod <= ma * mb;
                    r_step <= r_step + 5'd1;
                    if (r_step != ST_GRAV) begin
                        if (cstep < ST_FSQ) begin
                            r_fv[2'(cstep)] <= fsat[31:0];
                            r_ff <= r_ff | fsat[32];
                        end else if (cstep < ST_UF) begin
                            r_fsq <= r_fsq + r_prod[63:0];
                        end else if (cstep < ST_PSI) begin
                            r_p[4'(cstep - ST_UF)] <= rprod[55:0];
                        end else if (cstep == ST_PSI) begin
                            r_pp <= r_prod[62:0];
                        end else if (cstep == ST_SL) begin
                            r_a <= 53'({r_prod[48:0], 3'b0}) + 53'({r_prod[48:0], 2'b0});
                        end else if (cstep < ST_NUM) begin
                            r_q3[2'(cstep - ST_DIV3)] <= q3_val;
                        end else if (cstep == ST_NUM) begin
                            r_num <= r_num + 120'(r_prod[63:0]);
                        end else if (cstep == ST_NUM + 5'd3) begin
                            r_num <= r_num + (120'(r_prod[63:0]) << 64);
                        end else if (cstep < ST_DEN) begin
                            r_num <= r_num + (120'(r_prod[63:0]) << 32);
                        end else if (cstep == ST_DEN) begin
                            r_den <= r_den + 96'(r_prod[63:0]);
                        end else begin
                            r_den <= r_den + (96'(r_prod[63:0]) << 32);
                        end
                    end
                    if (r_step == ST_END) begin
                        r_state <= F_DSET;
                    end
                end
                F_DSET: begin
                    r_zdiv   <= (r_psi == '0) || (d_s == '0);
                    r_tfault <= 1'b0;
                    r_quo    <= '0;
                    if ((r_psi == '0) || (d_s == '0)) begin
                        r_state <= F_DONE;
                    end else if (160'(div_n) >= div_lim) begin
                        r_tfault <= 1'b1;
                        r_quo    <= 63'(1) << 62;
                        r_state  <= F_DONE;
                    end else begin
                        r_rem   <= div_n;
                        r_dsh   <= 160'(div_d) << 62;
                        r_cnt   <= 6'd62;
                        r_state <= F_DIV;
                    end
                end
                F_DIV: begin
                    // One quotient bit per cycle, most significant first.
                    if (160'(r_rem) >= r_dsh) begin
                        r_rem <= r_rem - 122'(r_dsh);
                        r_quo <= {r_quo[61:0], 1'b1};
                    end else begin
                        r_quo <= {r_quo[61:0], 1'b0};
                    end
                    r_dsh <= r_dsh >> 1;
                    r_cnt <= r_cnt - 6'd1;
                    if (r_cnt == '0) begin
                        r_state <= F_DONE;
                    end
                end
                F_DONE: begin
                    if (!i_full) begin
                        r_state <= F_IDLE;
                    end
                end
                default: r_state <= F_IDLE;
            endcase
        end
    end

    // Hand the finished cell to the queue.
    assign tmag   = {1'b0, r_quo};
    assign o_push = (r_state == F_DONE) && !i_full;
    assign o_busy = (r_state != F_IDLE);

    always_comb begin
        o_job.tag     = r_tag;
        for (int i = 0; i < 3; i++) begin
            o_job.fv[i] = r_fv[i];
            o_job.q3[i] = r_q3[i];
        end
        for (int i = 0; i < 9; i++) begin
            o_job.p[i] = r_p[i];
        end
        o_job.tension = (i_cfg.sigma[31] != d_s[33]) ? 64'(-tmag) : tmag;
        o_job.zdiv    = r_zdiv;
        o_job.s_neg   = i_cfg.sigma[31];
        o_job.tfault  = r_tfault;
        o_job.ff      = r_ff;
    end

endmodule

// ===== rtl/mfs_queue.sv =====
// Two-entry queue that decouples the front from the term emitter.
module mfs_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  mfs_pkg::t_job i_job,
    input  logic          i_pop,
    output logic          o_full,
    output logic          o_empty,
    output mfs_pkg::t_job o_head
);
    import mfs_pkg::*;

    t_job       r_mem [2];
    logic       r_wr;
    logic       r_rd;
    logic [1:0] r_count;

    assign o_full  = (r_count == 2'd2);
    assign o_empty = (r_count == 2'd0);
    assign o_head  = r_mem[r_rd];

    // Entry storage.
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_job;
        end
    end

    // Pointers and fill count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= 1'b0;
            r_rd    <= 1'b0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wr <= ~r_wr;
            end
            if (i_pop) begin
                r_rd <= ~r_rd;
            end
            r_count <= r_count + 2'(i_push) - 2'(i_pop);
        end
    end

endmodule

// ===== rtl/mfs_back.sv =====
// Back part: forms and saturates the fifteen moment terms of the head item.
module mfs_back #(
    parameter int TAG_BITS = 20
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_empty,
    input  mfs_pkg::t_job       i_head,
    output logic                o_pop,
    output logic                o_result_valid,
    output logic [TAG_BITS-1:0] o_tag_out,
    output logic [3:0]          o_moment_index,
    output logic signed [31:0]  o_term_value,
    output logic                o_last_term,
    output logic                o_arith_fault
);
    import mfs_pkg::*;

    localparam logic [3:0] M_DENSITY = 4'd0;
    localparam logic [3:0] M_ENERGY  = 4'd1;
    localparam logic [3:0] M_EPS     = 4'd2;
    localparam logic [3:0] M_JX      = 4'd3;
    localparam logic [3:0] M_QX      = 4'd4;
    localparam logic [3:0] M_JY      = 4'd5;
    localparam logic [3:0] M_QY      = 4'd6;
    localparam logic [3:0] M_JZ      = 4'd7;
    localparam logic [3:0] M_QZ      = 4'd8;
    localparam logic [3:0] M_PXX     = 4'd9;
    localparam logic [3:0] M_PWW     = 4'd10;
    localparam logic [3:0] M_PXY     = 4'd11;
    localparam logic [3:0] M_PYZ     = 4'd12;
    localparam logic [3:0] M_PXZ     = 4'd13;

    logic [3:0]         r_idx;
    logic signed [71:0] p [9];
    logic signed [71:0] udf;
    logic signed [71:0] val;
    logic               vforce;
    logic               vzero;
    logic [32:0]        sv;

    assign o_pop = !i_empty && (r_idx == MOMENT_LAST);

    // Sign-extended products of the head item.
    always_comb begin
        for (int i = 0; i < 9; i++) begin
            p[i] = {{16{i_head.p[i][55]}}, i_head.p[i]};
        end
    end
    assign udf = p[0] + p[4] + p[8];

    // Raw term of the current moment.
    always_comb begin
        val    = '0;
        vforce = 1'b0;
        vzero  = 1'b0;
        case (r_idx)
            M_DENSITY: vzero = 1'b1;
            M_ENERGY: begin
                if (i_head.zdiv) begin
                    val    = i_head.s_neg ? -72'sd2147483648 : 72'sd2147483647;
                    vforce = 1'b1;
                end else begin
                    val    = (udf <<< 1) + {{8{i_head.tension[63]}}, i_head.tension};
                    vforce = i_head.tfault;
                end
            end
            M_EPS:  val = 72'sd0 - (udf <<< 3) - (udf <<< 1);
            M_JX:   val = {{40{i_head.fv[0][31]}}, i_head.fv[0]};
            M_QX:   val = {{36{i_head.q3[0][35]}}, i_head.q3[0]};
            M_JY:   val = {{40{i_head.fv[1][31]}}, i_head.fv[1]};
            M_QY:   val = {{36{i_head.q3[1][35]}}, i_head.q3[1]};
            M_JZ:   val = {{40{i_head.fv[2][31]}}, i_head.fv[2]};
            M_QZ:   val = {{36{i_head.q3[2][35]}}, i_head.q3[2]};
            M_PXX:  val = (p[0] <<< 2) - (p[4] <<< 1) - (p[8] <<< 1);
            M_PWW:  val = (p[4] <<< 1) - (p[8] <<< 1);
            M_PXY:  val = p[1] + p[3];
            M_PYZ:  val = p[5] + p[7];
            M_PXZ:  val = p[2] + p[6];
            default: vzero = 1'b1;
        endcase
    end
    assign sv = sat32(val);

    // Output register and moment counter.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx          <= '0;
            o_result_valid <= 1'b0;
        end else begin
            o_result_valid <= !i_empty;
            if (!i_empty) begin
                r_idx <= (r_idx == MOMENT_LAST) ? 4'd0 : r_idx + 4'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        o_tag_out      <= i_head.tag[TAG_BITS-1:0];
        o_moment_index <= r_idx;
        o_term_value   <= sv[31:0];
        o_last_term    <= (r_idx == MOMENT_LAST);
        o_arith_fault  <= !vzero && (sv[32] || vforce || i_head.ff);
    end

endmodule

// ===== rtl/mrt_force_source_d3q15_core.sv =====
// Top level of the D3Q15 MRT forcing-term block: configuration, front, queue and back.
// Sequence: the front runs 26 serial multiplies and a 63-step radix-2 tension divider,
// then the item passes the queue and the output register; a zero divisor or clamp skips the divider.
// Throughput: the front, with its shared multiplier and divider, takes no new item until it has pushed the last one;
// the back then streams the 15 terms on consecutive cycles, one per cycle.
// Reset: synchronous, active low, restores register defaults; the receiver cannot stall.
module mrt_force_source_d3q15_core #(
    parameter int FRAC_BITS = 16,
    parameter int TAG_BITS  = 20
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_we,
    input  logic [2:0]          i_cfg_index,
    input  logic [31:0]         i_cfg_data,
    input  logic                start,
    output logic                busy,
    input  logic [TAG_BITS-1:0] i_cell_index,
    input  logic signed [31:0]  i_force_x,
    input  logic signed [31:0]  i_force_y,
    input  logic signed [31:0]  i_force_z,
    input  logic [30:0]         i_density,
    input  logic signed [31:0]  i_velocity_x,
    input  logic signed [31:0]  i_velocity_y,
    input  logic signed [31:0]  i_velocity_z,
    input  logic signed [31:0]  i_pseudo_potential,
    output logic                o_result_valid,
    output logic [TAG_BITS-1:0] o_tag_out,
    output logic [3:0]          o_moment_index,
    output logic signed [31:0]  o_term_value,
    output logic                o_last_term,
    output logic                o_arith_fault
);
    import mfs_pkg::*;

    t_cfg r_cfg;
    t_job push_job;
    t_job head_job;
    logic push;
    logic pop;
    logic full;
    logic empty;

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.ref_den <= REF_DEN_RESET;
            r_cfg.grav_x  <= '0;
            r_cfg.grav_y  <= '0;
            r_cfg.grav_z  <= '0;
            r_cfg.sigma   <= '0;
            r_cfg.lambda  <= LAMBDA_RESET;
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_index))
                CFG_REF_DEN: r_cfg.ref_den <= i_cfg_data[30:0];
                CFG_GRAV_X:  r_cfg.grav_x  <= i_cfg_data;
                CFG_GRAV_Y:  r_cfg.grav_y  <= i_cfg_data;
                CFG_GRAV_Z:  r_cfg.grav_z  <= i_cfg_data;
                CFG_SIGMA:   r_cfg.sigma   <= i_cfg_data;
                CFG_LAMBDA:  r_cfg.lambda  <= i_cfg_data[16:0];
                default: ;
            endcase
        end
    end

    mfs_front #(.FRAC_BITS(FRAC_BITS), .TAG_BITS(TAG_BITS)) u_front (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cfg              (r_cfg),
        .i_start            (start),
        .o_busy             (busy),
        .i_cell_index       (i_cell_index),
        .i_force_x          (i_force_x),
        .i_force_y          (i_force_y),
        .i_force_z          (i_force_z),
        .i_density          (i_density),
        .i_velocity_x       (i_velocity_x),
        .i_velocity_y       (i_velocity_y),
        .i_velocity_z       (i_velocity_z),
        .i_pseudo_potential (i_pseudo_potential),
        .i_full             (full),
        .o_push             (push),
        .o_job              (push_job)
    );

    mfs_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_job   (push_job),
        .i_pop   (pop),
        .o_full  (full),
        .o_empty (empty),
        .o_head  (head_job)
    );

    mfs_back #(.TAG_BITS(TAG_BITS)) u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_empty        (empty),
        .i_head         (head_job),
        .o_pop          (pop),
        .o_result_valid (o_result_valid),
        .o_tag_out      (o_tag_out),
        .o_moment_index (o_moment_index),
        .o_term_value   (o_term_value),
        .o_last_term    (o_last_term),
        .o_arith_fault  (o_arith_fault)
    );

endmodule

// ===== rtl/mfs_checker.sv =====
// Port-level checks of the forcing-term block and their binding to the top level.
module mfs_checker (
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              start,
    input logic              busy,
    input logic              o_result_valid,
    input logic [3:0]        o_moment_index,
    input logic signed [31:0] o_term_value,
    input logic              o_last_term,
    input logic              o_arith_fault
);
    import mfs_pkg::*;

    // The last flag marks exactly the final moment.
    a_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid |-> (o_last_term == (o_moment_index == MOMENT_LAST)))
        else $error("last_term does not match moment index");

    // Terms of one run come on consecutive cycles in rising order.
    a_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_result_valid && (o_moment_index != MOMENT_LAST)) |=>
        (o_result_valid && (o_moment_index == $past(o_moment_index) + 4'd1)))
        else $error("term run broken");

    // The constant moments are zero and never faulted.
    a_const: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_result_valid && ((o_moment_index == 4'd0) || (o_moment_index == MOMENT_LAST)))
        |-> ((o_term_value == 32'sd0) && !o_arith_fault))
        else $error("constant moment not zero");

    // An accepted item keeps the block busy in the next cycle.
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("accepted item did not raise busy");

endmodule

bind mrt_force_source_d3q15_core mfs_checker u_mfs_checker (.*);
